FILE: design/cmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmq_pkg
// shared types and codes of the coalescing message queue
// ----------------------------------------------------------------------------
package cmq_pkg;

  // operation codes on func_i
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // push status codes
  localparam logic [1:0] STATUS_APPENDED = 2'd0;
  localparam logic [1:0] STATUS_REPLACED = 2'd1;
  localparam logic [1:0] STATUS_DROPPED  = 2'd2;

  // occupancy field width on the result port
  localparam int unsigned OCC_W = 5;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming transaction
    logic lookup;   // key compare and head read
    logic commit;   // update store, pointers and result
  } cmd_t;

endpackage : cmq_pkg
`default_nettype wire

FILE: design/coalescing_message_queue_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// coalescing_message_queue_core
// fifo of keyed messages where a push with a queued key replaces the payload
// in place and a new key is dropped when full; pops return the head or report empty
// ----------------------------------------------------------------------------
// flow: an accepted transaction passes the lookup state, then the commit
//   state; done_o is registered from the commit state
// accept: busy stays high through lookup and commit, so no new transaction
//   is taken until the result cycle, in which busy is low again
// reset: asynchronous active low, empties the queue; the entry store is not
//   cleared, results are a one-cycle strobe that the receiver cannot stall
// ----------------------------------------------------------------------------
module coalescing_message_queue_core #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned KEY_BITS     = 8,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // command side
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      func_i,
  input  wire logic [KEY_BITS-1:0]       msg_key_i,
  input  wire logic [PAYLOAD_BITS-1:0]   msg_payload_i,
  // result side
  output logic                           done_o,
  output logic                           pop_valid_o,
  output logic      [KEY_BITS-1:0]       pop_key_o,
  output logic      [PAYLOAD_BITS-1:0]   pop_payload_o,
  output logic      [1:0]                push_status_o,
  output logic      [cmq_pkg::OCC_W-1:0] occupancy_o
);

  // command bus from the sequencer
  cmq_pkg::cmd_t cmd;

  // sequencer: a transaction is taken when start is high and busy is low,
  // then walks through a lookup state and a commit state
  cmq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // datapath: key lanes compare in parallel during lookup while the ram
  // reads the head entry; commit writes the ram, moves the pointers and
  // loads the result registers
  cmq_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .func_i        (func_i),
    .msg_key_i     (msg_key_i),
    .msg_payload_i (msg_payload_i),
    .pop_valid_o   (pop_valid_o),
    .pop_key_o     (pop_key_o),
    .pop_payload_o (pop_payload_o),
    .push_status_o (push_status_o),
    .occupancy_o   (occupancy_o)
  );

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");
  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && pop_valid_o) |-> push_status_o == cmq_pkg::STATUS_APPENDED)
    else $error("pop result carries a push status");
`endif

endmodule : coalescing_message_queue_core
`default_nettype wire

FILE: design/cmq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cmq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : cmq_ram
`default_nettype wire

FILE: design/cmq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmq_ctrl
// sequencer: idle, lookup, commit
// ----------------------------------------------------------------------------
module cmq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               done_o,
  output cmq_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept = start && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_LOOKUP;
            busy_q  <= 1'b1;
          end
        end
        ST_LOOKUP: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy          = busy_q;
  assign done_o        = done_q;
  assign cmd_o.capture = accept;
  assign cmd_o.lookup  = (state_q == ST_LOOKUP);
  assign cmd_o.commit  = (state_q == ST_COMMIT);

`ifndef ASSERT_OFF
  a_busy_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q == (state_q != ST_IDLE))
    else $error("busy out of step with state");
  a_done_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == ST_COMMIT)
    else $error("result strobe without commit");
  a_lookup_then_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP |=> state_q == ST_COMMIT)
    else $error("lookup not followed by commit");
`endif

endmodule : cmq_ctrl
`default_nettype wire

FILE: design/cmq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cmq_datapath
// key lanes, entry ram, head and count pointers, result registers
// ----------------------------------------------------------------------------
module cmq_datapath #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned KEY_BITS     = 8,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cmq_pkg::cmd_t               cmd_i,
  input  wire logic                        func_i,
  input  wire logic [KEY_BITS-1:0]         msg_key_i,
  input  wire logic [PAYLOAD_BITS-1:0]     msg_payload_i,
  output logic                             pop_valid_o,
  output logic      [KEY_BITS-1:0]         pop_key_o,
  output logic      [PAYLOAD_BITS-1:0]     pop_payload_o,
  output logic      [1:0]                  push_status_o,
  output logic      [cmq_pkg::OCC_W-1:0]   occupancy_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W = KEY_BITS + PAYLOAD_BITS;

  // captured transaction
  logic                    func_q;
  logic [KEY_BITS-1:0]     in_key_q;
  logic [PAYLOAD_BITS-1:0] in_payload_q;

  // queue state
  logic [IDX_W-1:0]        head_q, head_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [QUEUE_DEPTH-1:0]  valid_q, valid_d;
  logic [KEY_BITS-1:0]     slot_key_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]  match_q, match_d;

  // entry ram
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_rdata;

  // commit decode
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             full;
  logic [CNT_W:0]   tail_sum;
  logic [IDX_W-1:0] tail_idx;
  logic             do_append;
  logic             do_pop;

  // key compare, one lane per slot
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match_d[i] = valid_q[i] && (slot_key_q[i] == in_key_q);
    end
  end

  // at most one lane matches since keys are unique in the queue
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (match_q[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit  = |match_q;
  assign full = (count_q == CNT_W'(QUEUE_DEPTH));

  // tail slot = (head + count) mod depth
  always_comb begin
    tail_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
    if (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    tail_idx = tail_sum[IDX_W-1:0];
  end

  assign do_append = cmd_i.commit && (func_q == cmq_pkg::FUNC_PUSH) && !hit && !full;
  assign do_pop    = cmd_i.commit && (func_q == cmq_pkg::FUNC_POP) && (count_q != '0);
  assign ram_we    = cmd_i.commit && (func_q == cmq_pkg::FUNC_PUSH) && (hit || !full);
  assign ram_waddr = hit ? hit_idx : tail_idx;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    valid_d = valid_q;
    if (do_append) begin
      count_d           = count_q + CNT_W'(1);
      valid_d[tail_idx] = 1'b1;
    end
    if (do_pop) begin
      count_d         = count_q - CNT_W'(1);
      valid_d[head_q] = 1'b0;
      head_d = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      valid_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q       <= func_i;
      in_key_q     <= msg_key_i;
      in_payload_q <= msg_payload_i;
    end
    if (cmd_i.lookup) begin
      match_q <= match_d;
    end
    if (do_append) begin
      slot_key_q[tail_idx] <= in_key_q;
    end
    if (cmd_i.commit) begin
      occupancy_o <= cmq_pkg::OCC_W'(count_d);
      if (func_q == cmq_pkg::FUNC_PUSH) begin
        pop_valid_o   <= 1'b0;
        pop_key_o     <= '0;
        pop_payload_o <= '0;
        if (hit) begin
          push_status_o <= cmq_pkg::STATUS_REPLACED;
        end else if (full) begin
          push_status_o <= cmq_pkg::STATUS_DROPPED;
        end else begin
          push_status_o <= cmq_pkg::STATUS_APPENDED;
        end
      end else begin
        push_status_o <= cmq_pkg::STATUS_APPENDED;
        pop_valid_o   <= do_pop;
        pop_key_o     <= do_pop ? ram_rdata[ENT_W-1:PAYLOAD_BITS] : '0;
        pop_payload_o <= do_pop ? ram_rdata[PAYLOAD_BITS-1:0] : '0;
      end
    end
  end

  // entry store, key kept with payload for pop readout
  cmq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_key_q, in_payload_q}),
    .re_i    (cmd_i.lookup),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");
  a_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("valid bits disagree with entry count");
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> $onehot0(match_q))
    else $error("key present in more than one slot");
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> valid_q[head_q])
    else $error("head slot not valid in a non-empty queue");
`endif

endmodule : cmq_datapath
`default_nettype wire
